[src/n2a_pkg.sv]
// Shared constants, action codes and character helpers for the number-to-ASCII formatter.
`timescale 1ns / 1ps

package n2a_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int MAX_DEC_DIGITS   = 10;
  localparam int VALUE_W          = 32;
  localparam int DEC_W            = 4 * MAX_DEC_DIGITS;

  localparam logic [2:0] ACT_CHAR     = 3'd0;
  localparam logic [2:0] ACT_DECIMAL  = 3'd1;
  localparam logic [2:0] ACT_HEX_BYTE = 3'd2;
  localparam logic [2:0] ACT_HEX_WORD = 3'd3;
  localparam logic [2:0] ACT_REWIND   = 3'd4;

  localparam logic [7:0] ASC_ZERO   = 8'h30;
  localparam logic [7:0] ASC_X      = 8'h78;
  localparam logic [7:0] ASC_A_OFFS = 8'h37;  // 'A' - 10

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib & 4'h0F};
    if (ext <= 8'd9) begin
      return ext + ASC_ZERO;
    end
    return ext + ASC_A_OFFS;
  endfunction

endpackage

[src/n2a_bcd.sv]
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps

module n2a_bcd
  import n2a_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] bin,
  output logic               done,
  output logic [DEC_W-1:0]   bcd
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [DEC_W-1:0]   bcd_r, bcd_nxt;
  logic [DEC_W-1:0]   adj;

  // Correct every digit that would overflow on the next doubling.
  always_comb begin
    for (int i = 0; i < MAX_DEC_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bin_nxt  = bin;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      {bcd_nxt, bin_nxt} = {adj[DEC_W-2:0], bin_r, 1'b0};
      cnt_nxt            = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

[src/number_to_ascii_text_formatter.sv]
// Top level of the number-to-ASCII formatter: sequencer, position tracker and output register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake        Payload
// in_      input      in_valid/stall   action[3], value[32], digit_count[4]
// out_     output     out_valid/stall  char_code[8], position[6], stored, last
//
// Char mode emits one beat, hex byte two digit beats, hex word a "0x" prefix and
// eight digits. Decimal first runs the value through the shift-and-add-3 converter
// (one value bit per cycle), then emits digit_count beats, 10 at most; a zero count emits none.
// Rewind and unused action codes emit nothing.
// Emission advances one beat per cycle while the output register is free or being
// drained; an out_stall holds the sequencer. A new item is taken as soon as the
// last beat of the previous one sits in the output register.
// Synchronous active-low reset clears the write position and all control state.

module number_to_ascii_text_formatter
  import n2a_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   in_action,
  input  logic [31:0]  in_value,
  input  logic [3:0]   in_digit_count,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_char_code,
  output logic [5:0]   out_position,
  output logic         out_stored,
  output logic         out_last
);

  localparam int WP_W = $clog2(BUFFER_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [DEC_W-1:0] src_r, src_nxt;    // digits to emit: BCD or raw value
  logic [3:0]       idx_r, idx_nxt;    // digit index, counts down to zero
  logic [1:0]       pfx_r, pfx_nxt;    // "0x" prefix characters still to go
  logic [WP_W-1:0]  wp_r, wp_nxt;
  logic [WP_W+5:0]  wp_ext;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic             stored_r, stored_nxt;
  logic             last_r, last_nxt;

  logic             in_fire;
  logic             out_ok;
  logic             emit_fire;
  logic             emit_last;
  logic             has_room;
  logic [3:0]       nib;
  logic [7:0]       emit_char;
  logic [3:0]       cnt_sat;
  logic             conv_start;
  logic             conv_done;
  logic [DEC_W-1:0] conv_bcd;

  n2a_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (src_r[VALUE_W-1:0]),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_ok    = !out_valid_r || !out_stall;
  assign emit_fire = (state_r == S_EMIT) && out_ok;
  assign emit_last = (pfx_r == 2'd0) && (idx_r == 4'd0);
  assign has_room  = (wp_r < WP_W'(BUFFER_DEPTH));
  assign wp_ext    = {6'b000000, wp_r};

  // Kick the converter in the cycle after a decimal item is latched.
  assign conv_start = (state_r == S_CONV) && (pfx_r == 2'd3);

  assign cnt_sat = (in_digit_count > 4'(MAX_DEC_DIGITS)) ? 4'(MAX_DEC_DIGITS) : in_digit_count;
  assign nib     = src_r[{idx_r, 2'b00} +: 4];

  // Pick the character for the current beat.
  always_comb begin
    priority if (act_r == ACT_CHAR) begin
      emit_char = src_r[7:0];
    end else if (pfx_r == 2'd2) begin
      emit_char = ASC_ZERO;
    end else if (pfx_r == 2'd1) begin
      emit_char = ASC_X;
    end else if (act_r == ACT_DECIMAL) begin
      emit_char = ASC_ZERO + {4'b0000, nib};
    end else begin
      emit_char = hex_char(nib);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    src_nxt       = src_r;
    idx_nxt       = idx_r;
    pfx_nxt       = pfx_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    pos_nxt       = pos_r;
    stored_nxt    = stored_r;
    last_nxt      = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt = in_action;
          src_nxt = {{(DEC_W-VALUE_W){1'b0}}, in_value};
          pfx_nxt = 2'd0;
          unique case (in_action)
            ACT_CHAR: begin
              idx_nxt   = 4'd0;
              state_nxt = S_EMIT;
            end
            ACT_DECIMAL: begin
              // A zero digit count gives no beats at all.
              if (cnt_sat != 4'd0) begin
                idx_nxt   = cnt_sat - 4'd1;
                pfx_nxt   = 2'd3;      // marks the converter start cycle
                state_nxt = S_CONV;
              end
            end
            ACT_HEX_BYTE: begin
              idx_nxt   = 4'd1;
              state_nxt = S_EMIT;
            end
            ACT_HEX_WORD: begin
              idx_nxt   = 4'd7;
              pfx_nxt   = 2'd2;
              state_nxt = S_EMIT;
            end
            ACT_REWIND: begin
              wp_nxt = '0;
            end
            default: begin
              // Unused action codes: drop the item.
            end
          endcase
        end
      end
      S_CONV: begin
        pfx_nxt = 2'd0;
        if (conv_done) begin
          src_nxt   = conv_bcd;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          char_nxt      = emit_char;
          pos_nxt       = wp_ext[5:0];
          stored_nxt    = has_room;
          last_nxt      = emit_last;
          // Advance the write position only while the buffer has room.
          if (has_room) begin
            wp_nxt = wp_r + WP_W'(1);
          end
          if (pfx_r != 2'd0) begin
            pfx_nxt = pfx_r - 2'd1;
          end else if (!emit_last) begin
            idx_nxt = idx_r - 4'd1;
          end
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      pfx_r       <= 2'd0;
      idx_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
      pfx_r       <= pfx_nxt;
      idx_r       <= idx_nxt;
    end
    act_r    <= act_nxt;
    src_r    <= src_nxt;
    char_r   <= char_nxt;
    pos_r    <= pos_nxt;
    stored_r <= stored_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_position  = pos_r;
  assign out_stored    = stored_r;
  assign out_last      = last_r;

  // The write position never passes the buffer depth.
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WP_W'(BUFFER_DEPTH))
    else $error("write position beyond buffer depth");

  // A stored beat advances the write position by exactly one.
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && has_room) |=> (wp_r == $past(wp_r) + WP_W'(1)))
    else $error("write position did not advance on a stored beat");

  // The final beat of an item returns the sequencer to idle and flags last.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && emit_last) |=> (state_r == S_IDLE && out_valid_r && last_r))
    else $error("final beat did not close the item");

  // The converter reports completion only while the sequencer waits for it.
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == S_CONV))
    else $error("converter finished outside the conversion phase");

endmodule
